>>> src/spi_pkg.sv
`timescale 1ns / 1ps

package spi_pkg;

   // normal vector format, signed Q1.15
   localparam int NORM_W    = 16;
   localparam int NORM_FRAC = 15;

   // volume result, unsigned Q47.16
   localparam int VOL_W = 63;

   // pi/3 as unsigned Q1.63
   localparam logic [63:0] PI_THIRD_Q63 = 64'h860A_91C1_6B9B_2C23;

   typedef enum logic [1:0] {
      CLASS_FRONT  = 2'd0,
      CLASS_CUT    = 2'd1,
      CLASS_BEHIND = 2'd2
   } pos_class_type;

endpackage

>>> src/spi_req_if.sv
`timescale 1ns / 1ps

interface spi_req_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                                valid;
   logic                                ready;
   logic signed [COORD_WIDTH-1:0]       center_x;
   logic signed [COORD_WIDTH-1:0]       center_y;
   logic signed [COORD_WIDTH-1:0]       center_z;
   logic        [COORD_WIDTH-2:0]       sphere_radius;
   logic signed [COORD_WIDTH-1:0]       plane_point_x;
   logic signed [COORD_WIDTH-1:0]       plane_point_y;
   logic signed [COORD_WIDTH-1:0]       plane_point_z;
   logic signed [spi_pkg::NORM_W-1:0]   normal_x;
   logic signed [spi_pkg::NORM_W-1:0]   normal_y;
   logic signed [spi_pkg::NORM_W-1:0]   normal_z;

   modport source (
      output valid, center_x, center_y, center_z, sphere_radius,
             plane_point_x, plane_point_y, plane_point_z, normal_x, normal_y, normal_z,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, center_z, sphere_radius,
             plane_point_x, plane_point_y, plane_point_z, normal_x, normal_y, normal_z,
      output ready
   );
endinterface

>>> src/spi_rsp_if.sv
`timescale 1ns / 1ps

interface spi_rsp_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                             valid;
   logic                             ready;
   logic [spi_pkg::VOL_W-1:0]        volume_behind;
   logic [1:0]                       position_class;
   logic                             circle_hit;
   logic [COORD_WIDTH-2:0]           circle_radius;
   logic signed [COORD_WIDTH-1:0]    circle_center_x;
   logic signed [COORD_WIDTH-1:0]    circle_center_y;
   logic signed [COORD_WIDTH-1:0]    circle_center_z;

   modport source (
      output valid, volume_behind, position_class, circle_hit, circle_radius,
             circle_center_x, circle_center_y, circle_center_z,
      input  ready
   );
   modport sink (
      input  valid, volume_behind, position_class, circle_hit, circle_radius,
             circle_center_x, circle_center_y, circle_center_z,
      output ready
   );
endinterface

>>> src/sphere_plane_intersection.sv
`timescale 1ns / 1ps

// Sphere versus plane intersection, fully pipelined. One request is taken every
// cycle and one response leaves per request, in order. The pipe holds nine
// arithmetic stages (plane distance, classification, cap volume through split
// multiplies) followed by a one-bit-per-stage square root for the circle
// radius and an output register. The whole pipe moves together; when the
// response is held (rsp ready low with a valid response) every stage holds and
// req ready drops, so nothing is lost or repeated. The cap volume saturates at
// 2^63-1 and the circle center saturates at the coordinate range; without a hit
// the circle fields read zero. The normal is used as given (no normalization).
module sphere_plane_intersection #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   spi_req_if.sink    req_ch,
   spi_rsp_if.source  rsp_ch
);

   localparam int CW   = COORD_WIDTH;
   localparam int RW   = CW - 1;                       // radius / root width
   localparam int NW   = spi_pkg::NORM_W;
   localparam int NF   = spi_pkg::NORM_FRAC;
   localparam int PRW  = CW + 1 + NW;                  // normal times difference
   localparam int AW   = PRW + 2;                      // dot product sum
   localparam int DW   = AW - NF;                      // plane distance
   localparam int NDW  = CW + NW;                      // normal times distance
   localparam int PW   = 3 * CW + 1;                   // h^2 * (3r - h)
   localparam int QX_W = (PW + 1 > 65) ? PW + 1 : 65;
   localparam int RMW  = RW + 2;                       // root remainder
   localparam int VW   = spi_pkg::VOL_W;

   typedef struct packed {
      spi_pkg::pos_class_type  cls;
      logic                    hit;
      logic signed [CW-1:0]    ctr_x;
      logic signed [CW-1:0]    ctr_y;
      logic signed [CW-1:0]    ctr_z;
   } side_type;

   logic adv;
   logic out_v_ff;

   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // ---------------- stage 1: c - p ----------------
   logic                   v1_ff;
   logic signed [CW:0]     dx1_ff, dy1_ff, dz1_ff;
   logic signed [CW-1:0]   cx1_ff, cy1_ff, cz1_ff;
   logic signed [NW-1:0]   nx1_ff, ny1_ff, nz1_ff;
   logic [RW-1:0]          r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid;
      end
      if (adv) begin
         dx1_ff <= {req_ch.center_x[CW-1], req_ch.center_x}
                 - {req_ch.plane_point_x[CW-1], req_ch.plane_point_x};
         dy1_ff <= {req_ch.center_y[CW-1], req_ch.center_y}
                 - {req_ch.plane_point_y[CW-1], req_ch.plane_point_y};
         dz1_ff <= {req_ch.center_z[CW-1], req_ch.center_z}
                 - {req_ch.plane_point_z[CW-1], req_ch.plane_point_z};
         cx1_ff <= req_ch.center_x;
         cy1_ff <= req_ch.center_y;
         cz1_ff <= req_ch.center_z;
         nx1_ff <= req_ch.normal_x;
         ny1_ff <= req_ch.normal_y;
         nz1_ff <= req_ch.normal_z;
         r1_ff  <= req_ch.sphere_radius;
      end
   end

   // ---------------- stage 2: n_i * (c_i - p_i) ----------------
   logic                   v2_ff;
   logic signed [PRW-1:0]  px2_ff, py2_ff, pz2_ff;
   logic signed [CW-1:0]   cx2_ff, cy2_ff, cz2_ff;
   logic signed [NW-1:0]   nx2_ff, ny2_ff, nz2_ff;
   logic [RW-1:0]          r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         px2_ff <= PRW'(nx1_ff * dx1_ff);
         py2_ff <= PRW'(ny1_ff * dy1_ff);
         pz2_ff <= PRW'(nz1_ff * dz1_ff);
         cx2_ff <= cx1_ff;
         cy2_ff <= cy1_ff;
         cz2_ff <= cz1_ff;
         nx2_ff <= nx1_ff;
         ny2_ff <= ny1_ff;
         nz2_ff <= nz1_ff;
         r2_ff  <= r1_ff;
      end
   end

   // ---------------- stage 3: d = round(sum / 2^15) ----------------
   logic signed [AW-1:0]   acc3;
   logic                   v3_ff;
   logic signed [DW-1:0]   d3_ff;
   logic signed [CW-1:0]   cx3_ff, cy3_ff, cz3_ff;
   logic signed [NW-1:0]   nx3_ff, ny3_ff, nz3_ff;
   logic [RW-1:0]          r3_ff;

   always_comb begin
      acc3 = AW'(px2_ff) + AW'(py2_ff) + AW'(pz2_ff)
           + $signed(AW'(1) <<< (NF - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         d3_ff  <= acc3[AW-1:NF];
         cx3_ff <= cx2_ff;
         cy3_ff <= cy2_ff;
         cz3_ff <= cz2_ff;
         nx3_ff <= nx2_ff;
         ny3_ff <= ny2_ff;
         nz3_ff <= nz2_ff;
         r3_ff  <= r2_ff;
      end
   end

   // ---------------- stage 4: classify, cap height ----------------
   logic signed [DW-1:0]   rx4, hcut4, dneg4;
   logic                   cut4, hit4;
   spi_pkg::pos_class_type cls4;
   logic [CW-1:0]          h4;
   logic [CW:0]            t4;

   logic                   v4_ff;
   spi_pkg::pos_class_type cls4_ff;
   logic                   hit4_ff;
   logic [CW-1:0]          h4_ff;
   logic [CW:0]            t4_ff;
   logic [RW-1:0]          dabs4_ff;
   logic signed [CW-1:0]   dsc4_ff;
   logic signed [CW-1:0]   cx4_ff, cy4_ff, cz4_ff;
   logic signed [NW-1:0]   nx4_ff, ny4_ff, nz4_ff;
   logic [RW-1:0]          r4_ff;

   always_comb begin
      rx4   = $signed(DW'(r3_ff));
      dneg4 = -d3_ff;
      cut4  = (d3_ff > -rx4) && (d3_ff < rx4);
      hit4  = (d3_ff >= -rx4) && (d3_ff <= rx4);
      hcut4 = rx4 - d3_ff;
      if (cut4) begin
         cls4 = spi_pkg::CLASS_CUT;
      end else if (!d3_ff[DW-1]) begin
         cls4 = spi_pkg::CLASS_FRONT;
      end else begin
         cls4 = spi_pkg::CLASS_BEHIND;
      end
      // behind: full sphere is the cap at h = 2r
      h4 = cut4 ? hcut4[CW-1:0] : {r3_ff, 1'b0};
      t4 = ({1'b0, r3_ff, 1'b0} + {2'b00, r3_ff}) - {1'b0, h4};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         cls4_ff  <= cls4;
         hit4_ff  <= hit4;
         h4_ff    <= h4;
         t4_ff    <= t4;
         dabs4_ff <= d3_ff[DW-1] ? dneg4[RW-1:0] : d3_ff[RW-1:0];
         dsc4_ff  <= d3_ff[CW-1:0];
         cx4_ff   <= cx3_ff;
         cy4_ff   <= cy3_ff;
         cz4_ff   <= cz3_ff;
         nx4_ff   <= nx3_ff;
         ny4_ff   <= ny3_ff;
         nz4_ff   <= nz3_ff;
         r4_ff    <= r3_ff;
      end
   end

   // ---------------- stage 5: squares, n * d ----------------
   logic                   v5_ff;
   spi_pkg::pos_class_type cls5_ff;
   logic                   hit5_ff;
   logic [2*CW-1:0]        hsq5_ff;
   logic [CW:0]            t5_ff;
   logic [2*RW-1:0]        rsq5_ff, dsq5_ff;
   logic signed [NDW-1:0]  ndx5_ff, ndy5_ff, ndz5_ff;
   logic signed [CW-1:0]   cx5_ff, cy5_ff, cz5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         cls5_ff <= cls4_ff;
         hit5_ff <= hit4_ff;
         hsq5_ff <= (2*CW)'(h4_ff * h4_ff);
         t5_ff   <= t4_ff;
         rsq5_ff <= (2*RW)'(r4_ff * r4_ff);
         dsq5_ff <= (2*RW)'(dabs4_ff * dabs4_ff);
         ndx5_ff <= NDW'(nx4_ff * dsc4_ff);
         ndy5_ff <= NDW'(ny4_ff * dsc4_ff);
         ndz5_ff <= NDW'(nz4_ff * dsc4_ff);
         cx5_ff  <= cx4_ff;
         cy5_ff  <= cy4_ff;
         cz5_ff  <= cz4_ff;
      end
   end

   // ---------------- stage 6: split product, circle center ----------------
   function automatic logic signed [CW-1:0] ctr_sat(
      input logic signed [CW-1:0]  c,
      input logic signed [NDW-1:0] nd
   );
      logic signed [NDW:0]   s;
      logic signed [CW+2:0]  diff;
      logic signed [CW+2:0]  hi;
      logic signed [CW+2:0]  lo;
      s    = (NDW+1)'(nd) + $signed((NDW+1)'(1) <<< (NF - 1));
      diff = (CW+3)'(c) - (CW+3)'($signed(s[NDW:NF]));
      hi   = $signed({4'b0000, {(CW-1){1'b1}}});
      lo   = -hi - (CW+3)'(1);
      if (diff > hi) begin
         ctr_sat = hi[CW-1:0];
      end else if (diff < lo) begin
         ctr_sat = lo[CW-1:0];
      end else begin
         ctr_sat = diff[CW-1:0];
      end
   endfunction

   logic                   v6_ff;
   side_type               side6_ff;
   logic [2*CW:0]          pplo6_ff, pphi6_ff;
   logic [2*RW-1:0]        rad6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         side6_ff.cls   <= cls5_ff;
         side6_ff.hit   <= hit5_ff;
         side6_ff.ctr_x <= hit5_ff ? ctr_sat(cx5_ff, ndx5_ff) : '0;
         side6_ff.ctr_y <= hit5_ff ? ctr_sat(cy5_ff, ndy5_ff) : '0;
         side6_ff.ctr_z <= hit5_ff ? ctr_sat(cz5_ff, ndz5_ff) : '0;
         pplo6_ff       <= (2*CW+1)'(hsq5_ff[CW-1:0] * t5_ff);
         pphi6_ff       <= (2*CW+1)'(hsq5_ff[2*CW-1:CW] * t5_ff);
         rad6_ff        <= hit5_ff ? (rsq5_ff - dsq5_ff) : '0;
      end
   end

   // ---------------- stage 7: sum, round to FRAC_BITS ----------------
   logic [QX_W-1:0]        qsum7, qfull7;
   logic                   v7_ff;
   side_type               side7_ff;
   logic [63:0]            q7_ff;
   logic                   qovf7_ff;
   logic [2*RW-1:0]        rad7_ff;

   always_comb begin
      qsum7  = QX_W'(pplo6_ff) + (QX_W'(pphi6_ff) << CW)
             + (QX_W'(1) << (2*FRAC_BITS - 1));
      qfull7 = qsum7 >> (2*FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
      if (adv) begin
         side7_ff <= side6_ff;
         q7_ff    <= qfull7[63:0];
         qovf7_ff <= (qfull7 >> 64) != '0;
         rad7_ff  <= rad6_ff;
      end
   end

   // ---------------- stage 8: q * pi/3 partial products ----------------
   logic                   v8_ff;
   side_type               side8_ff;
   logic [63:0]            p00_8_ff, p01_8_ff, p10_8_ff, p11_8_ff;
   logic                   qovf8_ff;
   logic [2*RW-1:0]        rad8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff <= v7_ff;
      end
      if (adv) begin
         side8_ff <= side7_ff;
         p00_8_ff <= q7_ff[31:0]  * spi_pkg::PI_THIRD_Q63[31:0];
         p01_8_ff <= q7_ff[31:0]  * spi_pkg::PI_THIRD_Q63[63:32];
         p10_8_ff <= q7_ff[63:32] * spi_pkg::PI_THIRD_Q63[31:0];
         p11_8_ff <= q7_ff[63:32] * spi_pkg::PI_THIRD_Q63[63:32];
         qovf8_ff <= qovf7_ff;
         rad8_ff  <= rad7_ff;
      end
   end

   // ---------------- stage 9: sum, round by 2^63, saturate, zero in front ----------------
   logic [127:0]           vsum9;
   logic [64:0]            vfull9;
   logic [VW-1:0]          vol9;
   logic                   v9_ff;
   side_type               side9_ff;
   logic [VW-1:0]          vol9_ff;
   logic [2*RW-1:0]        rad9_ff;

   always_comb begin
      vsum9  = 128'(p00_8_ff) + (128'(p01_8_ff) << 32) + (128'(p10_8_ff) << 32)
             + (128'(p11_8_ff) << 64) + (128'(1) << 62);
      vfull9 = vsum9[127:63];
      if (side8_ff.cls == spi_pkg::CLASS_FRONT) begin
         vol9 = '0;
      end else if (qovf8_ff || (vfull9[64:VW] != '0)) begin
         vol9 = '1;
      end else begin
         vol9 = vfull9[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (adv) begin
         v9_ff <= v8_ff;
      end
      if (adv) begin
         side9_ff <= side8_ff;
         vol9_ff  <= vol9;
         rad9_ff  <= rad8_ff;
      end
   end

   // ---------------- square root, one root bit per stage ----------------
   logic                   sqv_ff    [RW];
   side_type               sqside_ff [RW];
   logic [VW-1:0]          sqvol_ff  [RW];
   logic [RMW-1:0]         sqrem_ff  [RW];
   logic [RW-1:0]          sqroot_ff [RW];
   logic [2*RW-1:0]        sqx_ff    [RW];

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      logic                v_in;
      side_type            side_in;
      logic [VW-1:0]       vol_in;
      logic [RMW-1:0]      rem_in;
      logic [RW-1:0]       root_in;
      logic [2*RW-1:0]     x_in;
      logic [RMW+1:0]      cur;
      logic [RMW+1:0]      trial;

      if (k == 0) begin : g_first
         assign v_in    = v9_ff;
         assign side_in = side9_ff;
         assign vol_in  = vol9_ff;
         assign rem_in  = '0;
         assign root_in = '0;
         assign x_in    = rad9_ff;
      end else begin : g_next
         assign v_in    = sqv_ff[k-1];
         assign side_in = sqside_ff[k-1];
         assign vol_in  = sqvol_ff[k-1];
         assign rem_in  = sqrem_ff[k-1];
         assign root_in = sqroot_ff[k-1];
         assign x_in    = sqx_ff[k-1];
      end

      always_comb begin
         cur   = {rem_in, x_in[2*RW-1:2*RW-2]};
         trial = (RMW+2)'({root_in, 2'b01});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[k] <= 1'b0;
         end else if (adv) begin
            sqv_ff[k] <= v_in;
         end
         if (adv) begin
            sqside_ff[k] <= side_in;
            sqvol_ff[k]  <= vol_in;
            sqx_ff[k]    <= x_in << 2;
            if (cur >= trial) begin
               sqrem_ff[k]  <= RMW'(cur - trial);
               sqroot_ff[k] <= {root_in[RW-2:0], 1'b1};
            end else begin
               sqrem_ff[k]  <= cur[RMW-1:0];
               sqroot_ff[k] <= {root_in[RW-2:0], 1'b0};
            end
         end
      end
   end

   // ---------------- output register, root rounded to nearest ----------------
   side_type               out_side_ff;
   logic [VW-1:0]          out_vol_ff;
   logic [RW-1:0]          out_rad_ff;
   logic [RW-1:0]          rad_in;

   always_comb begin
      rad_in = sqroot_ff[RW-1]
             + RW'(sqrem_ff[RW-1] > RMW'(sqroot_ff[RW-1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= sqv_ff[RW-1];
      end
      if (adv) begin
         out_side_ff <= sqside_ff[RW-1];
         out_vol_ff  <= sqvol_ff[RW-1];
         out_rad_ff  <= rad_in;
      end
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.volume_behind   = out_vol_ff;
   assign rsp_ch.position_class  = out_side_ff.cls;
   assign rsp_ch.circle_hit      = out_side_ff.hit;
   assign rsp_ch.circle_radius   = out_rad_ff;
   assign rsp_ch.circle_center_x = out_side_ff.ctr_x;
   assign rsp_ch.circle_center_y = out_side_ff.ctr_y;
   assign rsp_ch.circle_center_z = out_side_ff.ctr_z;

endmodule

>>> tb/tb_sphere_plane_intersection.sv
`timescale 1ns / 1ps

module tb_sphere_plane_intersection;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = 41;
   localparam logic [62:0] VOL_SAT = {63{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   spi_req_if #(.COORD_WIDTH(CW)) req_bus ();
   spi_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();

   sphere_plane_intersection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   typedef struct packed {
      logic signed [CW-1:0] cx, cy, cz;
      logic [CW-2:0]        rad;
      logic signed [CW-1:0] px, py, pz;
      logic signed [15:0]   nx, ny, nz;
   } sphere_plane_type;

   typedef struct packed {
      logic [62:0]          vol;
      logic [1:0]           cls;
      logic                 hit;
      logic [CW-2:0]        crad;
      logic signed [CW-1:0] ccx, ccy, ccz;
   } cut_result_type;

   cut_result_type expected_q[$];
   int  error_count = 0;
   bit  rsp_stall_enable = 1'b1;
   int  rsp_hold = 0;

   // floor division by 2^15 after adding half: round half toward +inf
   function automatic logic signed [127:0] round_q15(logic signed [127:0] v);
      return (v + 128'sd16384) >>> spi_pkg::NORM_FRAC;
   endfunction

   // h^2*(3r-h), rounded to Q.16, scaled by pi/3, rounded, saturated
   function automatic logic [62:0] cap_volume(logic [63:0] h, logic [63:0] r);
      logic [127:0] prod, q, v;
      prod = (h * h) * (3 * r - h);
      q = (prod + (128'd1 << (2 * FB - 1))) >> (2 * FB);
      if (q[127:64] != 0) return VOL_SAT;
      v = q * {64'd0, spi_pkg::PI_THIRD_Q63};
      v = (v + (128'd1 << 62)) >> 63;
      if (v > {65'd0, VOL_SAT}) return VOL_SAT;
      return v[62:0];
   endfunction

   function automatic logic [63:0] isqrt_round(logic [63:0] x);
      logic [63:0] res, bitv, rem;
      res = 0;
      bitv = 64'd1 << 62;
      rem = x;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      if (rem > res) res++;
      return res;
   endfunction

   function automatic cut_result_type predict_cut(sphere_plane_type s);
      cut_result_type o;
      logic signed [127:0] acc, plane_d, r, c[3], n[3], t;
      logic signed [127:0] cmax, cmin;
      cmax = (128'sd1 <<< (CW - 1)) - 1;
      cmin = -cmax - 1;
      c[0] = s.cx; c[1] = s.cy; c[2] = s.cz;
      n[0] = s.nx; n[1] = s.ny; n[2] = s.nz;
      acc = n[0] * (c[0] - s.px) + n[1] * (c[1] - s.py) + n[2] * (c[2] - s.pz);
      r = {97'd0, s.rad};
      plane_d = round_q15(acc);
      o = '0;
      if (plane_d > -r && plane_d < r) begin
         o.cls = spi_pkg::CLASS_CUT;
         o.vol = cap_volume(64'(r - plane_d), 64'(r));
      end else if (plane_d >= 0) begin
         o.cls = spi_pkg::CLASS_FRONT;
      end else begin
         o.cls = spi_pkg::CLASS_BEHIND;
         o.vol = cap_volume(64'(2 * r), 64'(r));
      end
      if (plane_d >= -r && plane_d <= r) begin
         o.hit  = 1'b1;
         o.crad = (CW-1)'(isqrt_round(64'(r * r - plane_d * plane_d)));
         for (int i = 0; i < 3; i++) begin
            t = c[i] - round_q15(n[i] * plane_d);
            if (t > cmax) t = cmax;
            if (t < cmin) t = cmin;
            if (i == 0) o.ccx = t[CW-1:0];
            else if (i == 1) o.ccy = t[CW-1:0];
            else o.ccz = t[CW-1:0];
         end
      end
      return o;
   endfunction

   function automatic int rand_gap();
      // mostly back to back, sometimes short, rarely long
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sends one request; valid stays high if the next call follows at once
   task automatic send_request(sphere_plane_type s, bit gaps = 1'b1);
      int gap;
      gap = gaps ? rand_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.center_x      <= s.cx;
      req_bus.center_y      <= s.cy;
      req_bus.center_z      <= s.cz;
      req_bus.sphere_radius <= s.rad;
      req_bus.plane_point_x <= s.px;
      req_bus.plane_point_y <= s.py;
      req_bus.plane_point_z <= s.pz;
      req_bus.normal_x      <= s.nx;
      req_bus.normal_y      <= s.ny;
      req_bus.normal_z      <= s.nz;
      do @(posedge clock); while (!req_bus.ready);
      expected_q.push_back(predict_cut(s));
   endtask

   task automatic release_bus();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // response sink: random stalls, mostly short and a few long
   always @(posedge clock) begin
      if (reset || !rsp_stall_enable) begin
         rsp_bus.ready <= 1'b1;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = rand_gap();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      cut_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response");
            error_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_bus.volume_behind !== exp_r.vol) begin
               $error("volume_behind exp %0d got %0d", exp_r.vol, rsp_bus.volume_behind);
               error_count++;
            end
            if (rsp_bus.position_class !== exp_r.cls) begin
               $error("position_class exp %0d got %0d", exp_r.cls, rsp_bus.position_class);
               error_count++;
            end
            if (rsp_bus.circle_hit !== exp_r.hit) begin
               $error("circle_hit exp %0d got %0d", exp_r.hit, rsp_bus.circle_hit);
               error_count++;
            end
            if (rsp_bus.circle_radius !== exp_r.crad) begin
               $error("circle_radius exp %0d got %0d", exp_r.crad, rsp_bus.circle_radius);
               error_count++;
            end
            if (rsp_bus.circle_center_x !== exp_r.ccx) begin
               $error("circle_center_x exp %0d got %0d", exp_r.ccx, rsp_bus.circle_center_x);
               error_count++;
            end
            if (rsp_bus.circle_center_y !== exp_r.ccy) begin
               $error("circle_center_y exp %0d got %0d", exp_r.ccy, rsp_bus.circle_center_y);
               error_count++;
            end
            if (rsp_bus.circle_center_z !== exp_r.ccz) begin
               $error("circle_center_z exp %0d got %0d", exp_r.ccz, rsp_bus.circle_center_z);
               error_count++;
            end
         end
      end
   end

   function automatic sphere_plane_type make_item(int cx, int cy, int cz, int rad,
                                                  int px, int py, int pz,
                                                  int nx, int ny, int nz);
      sphere_plane_type s;
      s.cx = cx; s.cy = cy; s.cz = cz; s.rad = rad[CW-2:0];
      s.px = px; s.py = py; s.pz = pz;
      s.nx = nx[15:0]; s.ny = ny[15:0]; s.nz = nz[15:0];
      return s;
   endfunction

   // random request; mode picks how close the plane is to the sphere
   function automatic sphere_plane_type random_item();
      sphere_plane_type s;
      int unsigned mode, axis;
      mode = $urandom_range(0, 9);
      s.cx = $urandom; s.cy = $urandom; s.cz = $urandom;
      s.px = $urandom; s.py = $urandom; s.pz = $urandom;
      s.nx = 16'($urandom); s.ny = 16'($urandom); s.nz = 16'($urandom);
      s.rad = (CW-1)'($urandom);
      if (mode < 6) begin
         // axis-aligned unit normal, plane near the center: mostly cuts
         axis = $urandom_range(0, 2);
         s.rad = (CW-1)'($urandom_range(0, 32'h00FF_FFFF));
         s.nx = '0; s.ny = '0; s.nz = '0;
         case (axis)
            0: s.nx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: s.ny = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: s.nz = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         endcase
         s.cx = $signed($urandom) >>> $urandom_range(4, 12);
         s.cy = $signed($urandom) >>> $urandom_range(4, 12);
         s.cz = $signed($urandom) >>> $urandom_range(4, 12);
         s.px = s.cx + ($signed($urandom) >>> $urandom_range(6, 14));
         s.py = s.cy + ($signed($urandom) >>> $urandom_range(6, 14));
         s.pz = s.cz + ($signed($urandom) >>> $urandom_range(6, 14));
      end else if (mode < 8) begin
         // oblique normal, moderate sizes
         s.nx = 16'($signed($urandom) >>> 1); s.ny = 16'($signed($urandom) >>> 1);
         s.nz = 16'($signed($urandom) >>> 1);
         s.rad = (CW-1)'($urandom_range(0, 32'h0FFF_FFFF));
         s.px = s.cx + ($signed($urandom) >>> 3);
         s.py = s.cy + ($signed($urandom) >>> 3);
         s.pz = s.cz + ($signed($urandom) >>> 3);
      end
      return s;
   endfunction

   task automatic test_directed();
      int one = 32'h0001_0000;
      int nmax = 32767;
      int nmin = -32768;
      // plane cuts through the center
      send_request(make_item(0, 0, 0, 4 * one, 0, 0, 0, 0, 0, nmax));
      // touching from the front: d == r, then d just inside r
      send_request(make_item(0, 0, 0, 2 * one, 0, 0, 2 * one, 0, 0, nmin));
      send_request(make_item(0, 0, 0, 32767, 0, 0, -32767, 0, 0, nmax));
      // d just inside -r, then touching from behind: d == -r
      send_request(make_item(0, 0, 0, 32767, 0, 0, 32767, 0, 0, nmax));
      send_request(make_item(0, 5 * one, 0, 5 * one, 0, 0, 0, 0, nmin, 0));
      // zero radius: on the plane, in front, behind
      send_request(make_item(one, one, one, 0, one, one, one, nmax, 0, 0));
      send_request(make_item(one, 0, 0, 0, 0, 0, 0, nmax, 0, 0));
      send_request(make_item(-one, 0, 0, 0, 0, 0, 0, nmax, 0, 0));
      // far in front, far behind
      send_request(make_item(100 * one, 0, 0, one, 0, 0, 0, nmax, 0, 0));
      send_request(make_item(-100 * one, 0, 0, one, 0, 0, 0, nmax, 0, 0));
      // largest radius: full volume saturates, then a plane through the center
      send_request(make_item(32'sh8000_0000, 0, 0, 32'h7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0,
                             nmax, 0, 0));
      send_request(make_item(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, nmin, nmin, nmin));
      // field extremes, normal not of unit length
      send_request(make_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'h7FFF_FFFF,
                             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                             nmax, nmin, nmax));
      send_request(make_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'h4000_0000,
                             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             nmin, nmin, nmin));
      // circle center near the coordinate edge, plane through the sphere center
      send_request(make_item(32'sh7FFF_FF00, 0, 0, 32'h7000_0000, 32'sh7FFF_FF00, 0, 0,
                             nmin, 0, 0));
      send_request(make_item(32'sh8000_0100, 0, 0, 32'h7000_0000, 32'sh8000_0100, 0, 0,
                             nmax, 0, 0));
      // zero normal: d == 0
      send_request(make_item(one, -one, one, 3 * one, 7, 9, 11, 0, 0, 0));
      // rounding half step in d
      send_request(make_item(1, 0, 0, 1, 0, 0, 0, 16384, 0, 0));
      send_request(make_item(-1, 0, 0, 1, 0, 0, 0, 16384, 0, 0));
      send_request(make_item(3 * one, 2 * one, -one, 6 * one, one, one, one,
                             23170, 23170, 0));
      release_bus();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_request(random_item());
      release_bus();
   endtask

   // back-to-back burst with the response side never stalling
   task automatic test_full_rate(int count);
      rsp_stall_enable = 1'b0;
      for (int i = 0; i < count; i++) send_request(random_item(), 1'b0);
      release_bus();
      rsp_stall_enable = 1'b1;
   endtask

   task automatic drain_responses();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.center_x = '0; req_bus.center_y = '0; req_bus.center_z = '0;
      req_bus.sphere_radius = '0;
      req_bus.plane_point_x = '0; req_bus.plane_point_y = '0; req_bus.plane_point_z = '0;
      req_bus.normal_x = '0; req_bus.normal_y = '0; req_bus.normal_z = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_responses();         // sender holds until every response is back
      test_random(250);
      test_full_rate(60);
      test_random(240);
      drain_responses();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
